// ===== src/integer_to_radix_ascii_assert.svh =====
// Assertion macros for the integer to radix ASCII converter.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/itra_pkg.sv =====
// Shared types, constants and the digit-to-character function for the
// integer to radix ASCII converter. No dependencies.
package itra_pkg;

	localparam int VALUE_BITS = 32;

	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;

	localparam logic [7:0] CHAR_NONE  = 8'h00;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;

	// format_flags bit positions
	localparam int FLAG_SIGNED = 0;
	localparam int FLAG_PLUS   = 1;
	localparam int FLAG_UPPER  = 2;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  radix;
		logic [2:0]  format_flags;
	} req_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last;
	} rsp_t;

	// Carry handed from one digit cell to the next more significant one.
	typedef struct packed {
		logic valid;
		logic carry;
	} itra_link_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic clear;
		logic shift;
	} itra_ctl_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
		logic [5:0] dc;
		dc = (d > 6'd35) ? 6'd35 : d;
		if (dc < 6'd10)
			return CHAR_ZERO + {2'b00, dc};
		else if (upper)
			return CHAR_UP_A + {2'b00, dc - 6'd10};
		else
			return CHAR_LOW_A + {2'b00, dc - 6'd10};
	endfunction

endpackage

// ===== src/integer_to_radix_ascii.sv =====
// Top level of the integer to radix ASCII converter: sequencer, output
// register and the row of digit cells. Depends on itra_pkg, itra_cell and
// integer_to_radix_ascii_assert.svh.
`include "integer_to_radix_ascii_assert.svh"

// Converts one 32-bit value per request beat into ASCII text in radix 2..36
// (out-of-range radix saturates), sent most significant character first, one
// character per response beat, last set on the final one. A row of 32 digit
// cells does the conversion: the magnitude is shifted in one bit per cycle,
// MSB first, and each cell doubles its digit, adds the carry from its
// neighbor and folds back by the radix, handing its carry on in the next
// cycle through a register. Leading zero digits are then shifted out of the
// top cell without output (one per cycle), and each remaining digit leaves
// the top cell as one beat. With a ready sink the sign character goes out
// during the conversion. A new request is taken once the last character
// sits in the output register, even if it has not been taken yet.
module integer_to_radix_ascii (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  itra_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output itra_pkg::rsp_t rsp
);
	import itra_pkg::*;

	localparam int CONV_LAST = 2 * VALUE_BITS - 2;
	localparam int CNT_W     = $clog2(2 * VALUE_BITS);
	localparam int REM_W     = $clog2(VALUE_BITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [REM_W-1:0]        rem_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [5:0]              radix_q;
	logic                    upper_q;
	logic [7:0]              sign_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    accept;
	logic [VALUE_BITS-1:0]   in_val;
	logic                    in_neg;
	logic [VALUE_BITS-1:0]   in_mag;
	logic [7:0]              in_sign;
	logic [5:0]              in_radix;
	logic                    feed;
	logic                    out_free;
	logic                    sign_load;
	logic                    emit_load;
	logic                    skip_shift;
	logic [5:0]              top_digit;

	itra_ctl_t               ctl;
	itra_link_t              link [0:VALUE_BITS];
	logic [5:0]              dig  [0:VALUE_BITS-1];

	// Request decode: magnitude, sign character and saturated radix.
	assign accept   = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign in_val   = req.value[VALUE_BITS-1:0];
	assign in_neg   = req.format_flags[FLAG_SIGNED] & in_val[VALUE_BITS-1];
	assign in_mag   = in_neg ? (VALUE_BITS'(0) - in_val) : in_val;
	assign in_sign  = in_neg ? CHAR_MINUS :
		(req.format_flags[FLAG_SIGNED] & req.format_flags[FLAG_PLUS]) ? CHAR_PLUS :
		CHAR_NONE;
	assign in_radix = (req.radix < RADIX_MIN) ? RADIX_MIN :
		(req.radix > RADIX_MAX) ? RADIX_MAX : req.radix;

	// Feed one magnitude bit per cycle during conversion until all VALUE_BITS bits are in.
	assign feed          = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_BITS));
	assign link[0].valid = feed;
	assign link[0].carry = val_q[VALUE_BITS-1];

	assign top_digit  = dig[VALUE_BITS-1];
	assign out_free   = !rsp_valid_q || rsp_ready;
	// The sign beat has priority; digits wait until it has gone.
	assign sign_load  = out_free && (sign_q != CHAR_NONE);
	assign emit_load  = (state_q == ST_EMIT) && out_free && (sign_q == CHAR_NONE);
	assign skip_shift = (state_q == ST_SKIP) && (top_digit == 6'd0) && (rem_q > REM_W'(1));

	assign ctl.clear = accept;
	assign ctl.shift = skip_shift || emit_load;

	genvar gi;
	generate
		for (gi = 0; gi < VALUE_BITS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				itra_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctl      (ctl),
					.radix    (radix_q),
					.link_in  (link[gi]),
					.link_out (link[gi+1]),
					.digit_in (6'd0),
					.digit_out(dig[gi])
				);
			end else begin : g_rest
				itra_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctl      (ctl),
					.radix    (radix_q),
					.link_in  (link[gi]),
					.link_out (link[gi+1]),
					.digit_in (dig[gi-1]),
					.digit_out(dig[gi])
				);
			end
		end
	endgenerate

	// Sequencer: convert, drop leading zeros, emit digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CONV_LAST)) begin
						state_q <= ST_SKIP;
						rem_q   <= REM_W'(VALUE_BITS);
					end
				end
				ST_SKIP: begin
					if (skip_shift)
						rem_q <= rem_q - 1'b1;
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == REM_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Magnitude shifter and per-item settings; hold outside their load points.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q   <= in_mag;
			radix_q <= in_radix;
			upper_q <= req.format_flags[FLAG_UPPER];
		end else if (feed) begin
			val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q <= CHAR_NONE;
		end else if (accept) begin
			sign_q <= in_sign;
		end else if (sign_load) begin
			sign_q <= CHAR_NONE;
		end
	end

	// Output register: one beat waits here while the sequencer moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (sign_load || emit_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sign_load) begin
			rsp_q.text_char <= sign_q;
			rsp_q.last      <= 1'b0;
		end else if (emit_load) begin
			rsp_q.text_char <= digit_char(top_digit, upper_q);
			rsp_q.last      <= (rem_q == REM_W'(1));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A carry out of the top cell would mean a lost digit.
	`ITRA_ASSERT_NOW(a_no_top_carry, link[VALUE_BITS].valid, !link[VALUE_BITS].carry, "carry out of top digit cell")
	// Every digit leaving the chain must be below the radix.
	`ITRA_ASSERT_NOW(a_digit_in_range, emit_load, top_digit < radix_q, "emitted digit not below radix")
	// An accepted request starts the conversion in the next cycle.
	`ITRA_ASSERT_NEXT(a_accept_starts, accept, (state_q == ST_CONV) && (cnt_q == '0), "conversion did not start after accept")

endmodule

// ===== src/itra_cell.sv =====
// One digit cell of the radix conversion chain: holds one digit in the
// current radix. Depends on itra_pkg.
module itra_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itra_pkg::itra_ctl_t  ctl,
	input  logic [5:0]           radix,
	input  itra_pkg::itra_link_t link_in,
	output itra_pkg::itra_link_t link_out,
	input  logic [5:0]           digit_in,
	output logic [5:0]           digit_out
);
	import itra_pkg::*;

	logic [5:0]  digit_q;
	itra_link_t  link_q;
	logic [6:0]  dbl;
	logic [6:0]  diff;
	logic        ge;

	// Double the digit and add the carry; fold back once if it reaches the radix.
	assign dbl  = {digit_q, link_in.carry};
	assign ge   = dbl >= {1'b0, radix};
	assign diff = dbl - {1'b0, radix};

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (link_in.valid) begin
			digit_q <= ge ? diff[5:0] : dbl[5:0];
		end else if (ctl.shift) begin
			digit_q <= digit_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (ctl.clear) begin
			link_q <= '0;
		end else begin
			link_q.valid <= link_in.valid;
			link_q.carry <= link_in.valid & ge;
		end
	end

	assign link_out  = link_q;
	assign digit_out = digit_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for integer_to_radix_ascii: a queue-fed request driver,
// a response monitor and an inline text predictor. Depends on itra_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import itra_pkg::*;

	// Digit alphabets, indexed by digit value.
	localparam string LOWER_ALPHABET = "0123456789abcdefghijklmnopqrstuvwxyz";
	localparam string UPPER_ALPHABET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	// Leave a margin after the last beat.
	localparam int DRAIN_CYCLES = 200;
	// Worst case is 33 characters per request under heavy output stall.
	// This limit is several times that case over the full request count.
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_REQUESTS = 480;
	localparam int REPORT_LIMIT = 10;

	// Flag combinations, written by name.
	localparam logic [2:0] FMT_UNSIGNED = 3'b000;
	localparam logic [2:0] FMT_SIGNED = 3'b001 << FLAG_SIGNED;
	localparam logic [2:0] FMT_PLUS = 3'b001 << FLAG_PLUS;
	localparam logic [2:0] FMT_UPPER = 3'b001 << FLAG_UPPER;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	req_t pending_requests[$];
	rsp_t expected_text[$];
	int request_total = 0;
	int requests_sent = 0;
	int sender_idle_pct = 36;
	int receiver_idle_pct = 83;
	int mismatches = 0;
	int cycle_count = 0;
	// Set at the rising edge when a request beat is taken; read by the driver at the falling edge.
	bit req_beat = 1'b0;

	integer_to_radix_ascii uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Work out the character beats that one request must produce, and queue them.
	function automatic void predict_text(input req_t r);
		logic [31:0] magnitude;
		logic [31:0] base;
		logic [5:0] digits [VALUE_BITS];
		int count;
		string alphabet;
		rsp_t beat;
		// Clamp the radix into 2..36.
		base = {26'd0, r.radix};
		if (r.radix < RADIX_MIN)
			base = {26'd0, RADIX_MIN};
		if (r.radix > RADIX_MAX)
			base = {26'd0, RADIX_MAX};
		alphabet = r.format_flags[FLAG_UPPER] ? UPPER_ALPHABET : LOWER_ALPHABET;
		magnitude = r.value;
		beat.last = 1'b0;
		// Sign handling applies in signed mode only; a lone plus flag does nothing.
		if (r.format_flags[FLAG_SIGNED]) begin
			if (r.value[VALUE_BITS-1]) begin
				beat.text_char = CHAR_MINUS;
				expected_text.push_back(beat);
				// Two's complement negate; the most negative value stays 2^31 as unsigned.
				magnitude = 32'd0 - r.value;
			end else if (r.format_flags[FLAG_PLUS]) begin
				beat.text_char = CHAR_PLUS;
				expected_text.push_back(beat);
			end
		end
		// Peel digits least significant first; zero still yields one digit.
		count = 0;
		do begin
			digits[count] = 6'(magnitude % base);
			magnitude = magnitude / base;
			count++;
		end while (magnitude != 0);
		// Emit most significant first, last set on the final digit.
		for (int k = count - 1; k >= 0; k--) begin
			beat.text_char = alphabet[digits[k]];
			beat.last = (k == 0);
			expected_text.push_back(beat);
		end
	endfunction

	task automatic add_request(input logic [31:0] value, input logic [5:0] radix,
			input logic [2:0] flags);
		req_t r;
		r.value = value;
		r.radix = radix;
		r.format_flags = flags;
		pending_requests.push_back(r);
	endtask

	// Random value drawn from a few shapes: full range, tiny, near the sign
	// boundary or the top, and a full-range value cut down to a random length.
	function automatic logic [31:0] random_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(40);
			2: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(8) - 4
					: 32'hFFFF_FFFF - $urandom_range(8);
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// Request driver: hold a beat until it is taken, then advance or idle.
	// Idling follows three phases over the request count: sender light and
	// receiver heavy, then the reverse, then no idling at all.
	always @(negedge clk) begin
		if (arst_n) begin
			if (requests_sent < request_total / 3) begin
				sender_idle_pct = 36;
				receiver_idle_pct = 83;
			end else if (requests_sent < 2 * request_total / 3) begin
				sender_idle_pct = 83;
				receiver_idle_pct = 36;
			end else begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			if (!req_valid || req_beat) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					req <= pending_requests.pop_front();
					req_valid <= 1'b1;
					requests_sent++;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Monitor: predict on each request beat, check each response beat
	// against the oldest expected character.
	always @(posedge clk) begin
		rsp_t want;
		req_beat = arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_text.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected beat char=%h last=%b",
							$realtime, rsp.text_char, rsp.last);
				end else begin
					want = expected_text.pop_front();
					if (rsp.text_char !== want.text_char || rsp.last !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: expected char=%h last=%b, got char=%h last=%b",
								$realtime, want.text_char, want.last, rsp.text_char, rsp.last);
					end
				end
			end
			// Predict after the response check so a same-edge beat is matched
			// against the earlier request's text first.
			if (req_beat)
				predict_text(req);
		end
	end

	// Watchdog for a hung block.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [5:0] radix;

		// Directed cases: zero, longest outputs, the most negative value,
		// sign and plus handling, radix clamping at both ends, letter case.
		add_request(32'd0, 6'd10, FMT_UNSIGNED);
		add_request(32'd0, 6'd10, FMT_SIGNED | FMT_PLUS);
		add_request(32'hFFFF_FFFF, 6'd2, FMT_UNSIGNED);
		add_request(32'hFFFF_FFFF, 6'd36, FMT_UPPER);
		add_request(32'hFFFF_FFFF, 6'd36, FMT_UNSIGNED);
		add_request(32'hFFFF_FFFF, 6'd10, FMT_SIGNED);
		add_request(32'h8000_0000, 6'd2, FMT_SIGNED);
		add_request(32'h8000_0000, 6'd10, FMT_SIGNED | FMT_PLUS | FMT_UPPER);
		add_request(32'h8000_0000, 6'd16, FMT_UNSIGNED);
		add_request(32'h7FFF_FFFF, 6'd16, FMT_SIGNED | FMT_PLUS);
		add_request(32'h7FFF_FFFF, 6'd16, FMT_SIGNED | FMT_PLUS | FMT_UPPER);
		add_request(32'd123, 6'd10, FMT_PLUS);
		add_request(32'd35, 6'd36, FMT_UNSIGNED);
		add_request(32'd35, 6'd36, FMT_UPPER);
		add_request(32'd5, 6'd0, FMT_UNSIGNED);
		add_request(32'd5, 6'd1, FMT_UNSIGNED);
		add_request(32'd1295, 6'd37, FMT_UNSIGNED);
		add_request(32'd1295, 6'd63, FMT_UPPER);
		add_request(32'd1, 6'd2, FMT_UNSIGNED);
		add_request(32'hFFFF_FF85, 6'd8, FMT_SIGNED | FMT_PLUS | FMT_UPPER);
		add_request(32'hDEAD_BEEF, 6'd16, FMT_UPPER);
		add_request(32'd4294967295, 6'd3, FMT_SIGNED | FMT_PLUS);

		// Random part: mostly legal radices, some drawn from the full field.
		repeat (RANDOM_REQUESTS) begin
			radix = ($urandom_range(99) < 85) ? 6'($urandom_range(2, 36)) : 6'($urandom_range(63));
			add_request(random_value(), radix, 3'($urandom_range(7)));
		end
		request_total = pending_requests.size();

		// Hold reset, then release it away from the rising edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all requests taken, every character seen, then a quiet margin.
		while (pending_requests.size() > 0 || req_valid)
			@(posedge clk);
		while (expected_text.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_text.size() > 0)
			mismatches++;
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
